[src/mnps_pkg.sv]
// ----------------------------------------------------------------------------
// mnps_pkg
// Shared types, codes and sizes for the monophonic note priority stack.
// ----------------------------------------------------------------------------
package mnps_pkg;

  // held-note stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // fixed field widths
  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int LEVEL_W = 8;
  localparam int HELD_W  = 5;
  localparam int REQ_W   = 2;
  localparam int ACT_W   = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_NOTE_ON  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALL_OFF  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RSVD     = 2'd3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RETRIG   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SLIDE    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_GATE_OFF = 2'd3;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SEQ_RUNNING = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ACC_THRESH  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ACC_AMOUNT  = 2'd2;

  // configuration reset values
  localparam logic [VEL_W-1:0]   ACC_THRESH_RST = 7'd96;
  localparam logic [LEVEL_W-1:0] ACC_AMOUNT_RST = 8'd255;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic walk_done;
    logic skip_walk;
  } dp_status_t;

endpackage

[src/mono_note_priority_stack.sv]
// ----------------------------------------------------------------------------
// mono_note_priority_stack
// Last-note-priority held-note stack driving a monophonic bass voice.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  : in_valid / in_stall with req_type, note_number, velocity
//   output channel : out_valid / out_stall with one result item per input item
//   config channel : cfg_valid / cfg_ready (always ready), cfg_index, cfg_data;
//                    write only while no item is in flight
// Sequence: capture, a walk over the stack that steps through the held
//   notes in turn, a check for the end of the walk, then commit. The time an
//   item takes before its result shows grows with the notes held, up to a
//   full stack of 16, since the walk covers the stack registers. All-notes-off,
//   reserved requests and events while the sequencer runs skip the walk.
// Throughput: one item at a time; the next item is taken as soon as the
//   previous one has moved into the output register.
// Stall: a result waits in the output register while out_stall is high; the
//   next item may still be taken and walked, but it holds in its commit
//   cycle until the output register frees up.
// Reset: empty stack, gate closed, velocity and accent zero, sequencer off,
//   threshold 96, accent amount 255.
// ----------------------------------------------------------------------------
module mono_note_priority_stack (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mnps_pkg::REQ_W-1:0]      req_type,
  input  logic [mnps_pkg::NOTE_W-1:0]     note_number,
  input  logic [mnps_pkg::VEL_W-1:0]      velocity,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mnps_pkg::ACT_W-1:0]      action,
  output logic [mnps_pkg::NOTE_W-1:0]     target_note,
  output logic                            accent_flag,
  output logic [mnps_pkg::LEVEL_W-1:0]    accent_level,
  output logic [mnps_pkg::VEL_W-1:0]      voice_velocity,
  output logic [mnps_pkg::HELD_W-1:0]     notes_held,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mnps_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [mnps_pkg::CDATA_W-1:0]    cfg_data
);

  mnps_pkg::ctrl_cmd_t  cmd;
  mnps_pkg::dp_status_t status;

  // config writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencer
  mnps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // stack and result datapath
  mnps_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .note_number    (note_number),
    .velocity       (velocity),
    .action         (action),
    .target_note    (target_note),
    .accent_flag    (accent_flag),
    .accent_level   (accent_level),
    .voice_velocity (voice_velocity),
    .notes_held     (notes_held)
  );

endmodule

[src/mnps_ctrl.sv]
// ----------------------------------------------------------------------------
// mnps_ctrl
// Sequencer for one item: capture, walk the stack, then commit and present.
// ----------------------------------------------------------------------------
module mnps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  mnps_pkg::dp_status_t status,
  output mnps_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t state;
  logic   out_free;

  // output register can take a new item
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != ST_IDLE);

  // command decode
  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.step   = (state == ST_WALK) && !status.walk_done && !status.skip_walk;
    cmd.finish = (state == ST_DONE) && out_free;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // set on commit, cleared once the item is taken
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (status.walk_done || status.skip_walk) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[src/mnps_datapath.sv]
// ----------------------------------------------------------------------------
// mnps_datapath
// Note stack, compaction walk, config registers and result registers.
// ----------------------------------------------------------------------------
module mnps_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  mnps_pkg::ctrl_cmd_t             cmd,
  output mnps_pkg::dp_status_t            status,
  input  logic                            cfg_valid,
  input  logic [mnps_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [mnps_pkg::CDATA_W-1:0]    cfg_data,
  input  logic [mnps_pkg::REQ_W-1:0]      req_type,
  input  logic [mnps_pkg::NOTE_W-1:0]     note_number,
  input  logic [mnps_pkg::VEL_W-1:0]      velocity,
  output logic [mnps_pkg::ACT_W-1:0]      action,
  output logic [mnps_pkg::NOTE_W-1:0]     target_note,
  output logic                            accent_flag,
  output logic [mnps_pkg::LEVEL_W-1:0]    accent_level,
  output logic [mnps_pkg::VEL_W-1:0]      voice_velocity,
  output logic [mnps_pkg::HELD_W-1:0]     notes_held
);

  localparam logic [mnps_pkg::CNT_W-1:0] DEPTH_CNT = mnps_pkg::CNT_W'(mnps_pkg::STACK_DEPTH);

  // stack storage, valid only below the count
  logic [mnps_pkg::NOTE_W-1:0] note_stack [mnps_pkg::STACK_DEPTH];

  // persistent state
  logic [mnps_pkg::CNT_W-1:0]   stack_count;
  logic                         gate_open;
  logic [mnps_pkg::VEL_W-1:0]   last_velocity;
  logic [mnps_pkg::LEVEL_W-1:0] voice_accent;

  // configuration
  logic                         seq_running;
  logic [mnps_pkg::VEL_W-1:0]   accent_threshold;
  logic [mnps_pkg::LEVEL_W-1:0] accent_amount;

  // captured item and walk state
  logic [mnps_pkg::REQ_W-1:0]  req;
  logic [mnps_pkg::NOTE_W-1:0] note;
  logic [mnps_pkg::VEL_W-1:0]  vel;
  logic [mnps_pkg::CNT_W-1:0]  rd_ptr;
  logic [mnps_pkg::CNT_W-1:0]  wr_ptr;
  logic                        found;
  logic                        top_hit;

  logic [mnps_pkg::IDX_W-1:0]  rd_idx;
  logic [mnps_pkg::NOTE_W-1:0] rd_data;
  logic [mnps_pkg::CNT_W-1:0]  wr_ptr_dec;
  logic                        accent;

  // commit values
  logic [mnps_pkg::ACT_W-1:0]   action_next;
  logic [mnps_pkg::NOTE_W-1:0]  target_next;
  logic                         flag_next;
  logic [mnps_pkg::LEVEL_W-1:0] level_next;
  logic [mnps_pkg::CNT_W-1:0]   count_next;
  logic                         gate_next;
  logic [mnps_pkg::LEVEL_W-1:0] vaccent_next;
  logic [mnps_pkg::VEL_W-1:0]   lvel_next;
  logic                         push;

  // single read port: walk pointer, or new top at commit
  assign wr_ptr_dec = wr_ptr - 1'b1;
  assign rd_idx     = cmd.finish ? wr_ptr_dec[mnps_pkg::IDX_W-1:0]
                                 : rd_ptr[mnps_pkg::IDX_W-1:0];
  assign rd_data    = note_stack[rd_idx];

  assign accent = (vel >= accent_threshold);

  // status to controller
  always_comb begin
    status.walk_done = (rd_ptr == stack_count);
    status.skip_walk = (req == mnps_pkg::REQ_ALL_OFF) || (req == mnps_pkg::REQ_RSVD) ||
                       seq_running;
  end

  // result and state update for the commit cycle
  always_comb begin
    action_next  = mnps_pkg::ACT_NONE;
    target_next  = '0;
    flag_next    = 1'b0;
    level_next   = '0;
    count_next   = stack_count;
    gate_next    = gate_open;
    vaccent_next = voice_accent;
    lvel_next    = last_velocity;
    push         = 1'b0;
    case (req)
      mnps_pkg::REQ_ALL_OFF: begin
        count_next  = '0;
        gate_next   = 1'b0;
        action_next = mnps_pkg::ACT_GATE_OFF;
      end
      mnps_pkg::REQ_NOTE_ON: begin
        if (!seq_running) begin
          lvel_next = vel;
          push      = (wr_ptr != DEPTH_CNT);
          count_next = push ? wr_ptr + 1'b1 : wr_ptr;
          if ((stack_count != '0) && gate_open) begin
            action_next = mnps_pkg::ACT_SLIDE;
            if (accent) begin
              vaccent_next = accent_amount;
            end
          end else begin
            action_next  = mnps_pkg::ACT_RETRIG;
            vaccent_next = accent ? accent_amount : '0;
          end
          gate_next   = 1'b1;
          target_next = note;
          flag_next   = accent;
          level_next  = vaccent_next;
        end
      end
      mnps_pkg::REQ_NOTE_OFF: begin
        if (!seq_running && found) begin
          count_next = wr_ptr;
          if (wr_ptr == '0) begin
            gate_next   = 1'b0;
            action_next = mnps_pkg::ACT_GATE_OFF;
          end else if (top_hit) begin
            gate_next   = 1'b1;
            action_next = mnps_pkg::ACT_SLIDE;
            target_next = rd_data;
            level_next  = voice_accent;
          end
        end
      end
      default: begin
        action_next = mnps_pkg::ACT_NONE;
      end
    endcase
  end

  // capture, walk and compaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= req_type;
      note    <= note_number;
      vel     <= velocity;
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      found   <= 1'b0;
      top_hit <= 1'b0;
    end else if (cmd.step) begin
      rd_ptr <= rd_ptr + 1'b1;
      if (rd_data != note) begin
        note_stack[wr_ptr[mnps_pkg::IDX_W-1:0]] <= rd_data;
        wr_ptr <= wr_ptr + 1'b1;
      end else begin
        found <= 1'b1;
        if (rd_ptr + 1'b1 == stack_count) begin
          top_hit <= 1'b1;
        end
      end
    end else if (cmd.finish && push) begin
      note_stack[wr_ptr[mnps_pkg::IDX_W-1:0]] <= note;
    end
  end

  // voice state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count      <= '0;
      gate_open        <= 1'b0;
      last_velocity    <= '0;
      voice_accent     <= '0;
      seq_running      <= 1'b0;
      accent_threshold <= mnps_pkg::ACC_THRESH_RST;
      accent_amount    <= mnps_pkg::ACC_AMOUNT_RST;
    end else begin
      if (cmd.finish) begin
        stack_count   <= count_next;
        gate_open     <= gate_next;
        last_velocity <= lvel_next;
        voice_accent  <= vaccent_next;
      end
      if (cfg_valid) begin
        case (cfg_index)
          mnps_pkg::CFG_SEQ_RUNNING: seq_running      <= cfg_data[0];
          mnps_pkg::CFG_ACC_THRESH:  accent_threshold <= cfg_data[mnps_pkg::VEL_W-1:0];
          mnps_pkg::CFG_ACC_AMOUNT:  accent_amount    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      action         <= action_next;
      target_note    <= target_next;
      accent_flag    <= flag_next;
      accent_level   <= level_next;
      voice_velocity <= lvel_next;
      notes_held     <= mnps_pkg::HELD_W'(count_next);
    end
  end

endmodule

[tb/mnps_voice_checker.sv]
// ----------------------------------------------------------------------------
// mnps_voice_checker
// Watches the event, result and register channels of the note priority
// stack, keeps its own copy of the held-note stack and voice state, predicts
// one result per accepted event and compares results in order.
// ----------------------------------------------------------------------------
module mnps_voice_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [mnps_pkg::REQ_W-1:0]   req_type,
  input  logic [mnps_pkg::NOTE_W-1:0]  note_number,
  input  logic [mnps_pkg::VEL_W-1:0]   velocity,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [mnps_pkg::ACT_W-1:0]   action,
  input  logic [mnps_pkg::NOTE_W-1:0]  target_note,
  input  logic                         accent_flag,
  input  logic [mnps_pkg::LEVEL_W-1:0] accent_level,
  input  logic [mnps_pkg::VEL_W-1:0]   voice_velocity,
  input  logic [mnps_pkg::HELD_W-1:0]  notes_held,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [mnps_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [mnps_pkg::CDATA_W-1:0] cfg_data,
  output int                           fail_count,
  output int                           pending
);
  import mnps_pkg::*;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [NOTE_W-1:0]  note;
    logic               flag;
    logic [LEVEL_W-1:0] level;
    logic [VEL_W-1:0]   vel;
    logic [HELD_W-1:0]  held;
  } voice_result_t;

  // shadow of the held-note stack and the voice
  logic [NOTE_W-1:0]  held_notes [STACK_DEPTH];
  int                 held_cnt;
  logic               gate_on;
  logic [VEL_W-1:0]   last_vel;
  logic [LEVEL_W-1:0] voice_acc;

  // shadow of the register file
  logic               seq_run;
  logic [VEL_W-1:0]   acc_thr;
  logic [LEVEL_W-1:0] acc_amt;

  voice_result_t voice_q [$];
  int            mismatches = 0;

  // apply one event to the shadow stack and return the voice result it gives
  function automatic voice_result_t next_result(input logic [REQ_W-1:0] req,
                                                input logic [NOTE_W-1:0] note,
                                                input logic [VEL_W-1:0] vel);
    voice_result_t r;
    logic          accented;
    logic          had_notes;
    logic          found;
    logic          was_top;
    int            i;
    int            w;
    int            pos;
    r = '0;
    if (req == REQ_ALL_OFF) begin
      held_cnt = 0;
      gate_on  = 1'b0;
      r.act    = ACT_GATE_OFF;
    end else if (req == REQ_RSVD || seq_run) begin
      r.act = ACT_NONE;
    end else if (req == REQ_NOTE_ON) begin
      accented  = (vel >= acc_thr);
      had_notes = (held_cnt != 0);
      last_vel  = vel;
      // drop every copy of the note, then push it if there is room
      w = 0;
      for (i = 0; i < held_cnt; i++) begin
        if (held_notes[i] != note) begin
          held_notes[w] = held_notes[i];
          w++;
        end
      end
      held_cnt = w;
      if (held_cnt < STACK_DEPTH) begin
        held_notes[held_cnt] = note;
        held_cnt++;
      end
      if (had_notes && gate_on) begin
        r.act = ACT_SLIDE;
        if (accented) voice_acc = acc_amt;
      end else begin
        r.act     = ACT_RETRIG;
        voice_acc = accented ? acc_amt : '0;
      end
      gate_on = 1'b1;
      r.note  = note;
      r.flag  = accented;
      r.level = voice_acc;
    end else begin
      // note off: last matching entry wins
      found = 1'b0;
      pos   = 0;
      for (i = 0; i < held_cnt; i++) begin
        if (held_notes[i] == note) begin
          pos   = i;
          found = 1'b1;
        end
      end
      if (found) begin
        was_top = (pos + 1 == held_cnt);
        for (i = pos; i + 1 < held_cnt; i++) held_notes[i] = held_notes[i + 1];
        held_cnt--;
        if (held_cnt == 0) begin
          gate_on = 1'b0;
          r.act   = ACT_GATE_OFF;
        end else if (was_top) begin
          gate_on = 1'b1;
          r.act   = ACT_SLIDE;
          r.note  = held_notes[held_cnt - 1];
          r.level = voice_acc;
        end
      end
    end
    r.vel  = last_vel;
    r.held = HELD_W'(held_cnt);
    return r;
  endfunction

  // track register writes, events and results at each edge
  always @(posedge clk) begin
    voice_result_t got;
    voice_result_t want;
    if (rst) begin
      held_cnt  = 0;
      gate_on   = 1'b0;
      last_vel  = '0;
      voice_acc = '0;
      seq_run   = 1'b0;
      acc_thr   = ACC_THRESH_RST;
      acc_amt   = ACC_AMOUNT_RST;
      voice_q.delete();
    end else begin
      // compare before queuing so a result never meets its own event
      if (out_valid && !out_stall) begin
        got = '{action, target_note, accent_flag, accent_level, voice_velocity, notes_held};
        if (voice_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: act=%0d note=%0d acc=%0b lvl=%0d vel=%0d held=%0d",
                     got.act, got.note, got.flag, got.level, got.vel, got.held);
        end else begin
          want = voice_q.pop_front();
          if (got.act !== want.act || got.note !== want.note || got.flag !== want.flag ||
              got.level !== want.level || got.vel !== want.vel || got.held !== want.held) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp act=%0d note=%0d acc=%0b lvl=%0d vel=%0d held=%0d, got act=%0d note=%0d acc=%0b lvl=%0d vel=%0d held=%0d",
                       want.act, want.note, want.flag, want.level, want.vel, want.held,
                       got.act, got.note, got.flag, got.level, got.vel, got.held);
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEQ_RUNNING: seq_run = cfg_data[0];
          CFG_ACC_THRESH:  acc_thr = cfg_data[VEL_W-1:0];
          CFG_ACC_AMOUNT:  acc_amt = cfg_data;
          default: ;
        endcase
      end
      // accepted event
      if (in_valid && !in_stall)
        voice_q.push_back(next_result(req_type, note_number, velocity));
    end
    pending    <= voice_q.size();
    fail_count <= mismatches;
  end

endmodule

[tb/tb_mono_note_priority_stack.sv]
// ----------------------------------------------------------------------------
// tb_mono_note_priority_stack
// Drives note events and register writes into the note priority stack under
// random sender gaps and receiver stalls; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_mono_note_priority_stack;
  import mnps_pkg::*;

  localparam int                LIMIT      = 1000000;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  // receiver stall patterns
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_RUNS  = 3;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_stall;
  logic [REQ_W-1:0]    req_type    = '0;
  logic [NOTE_W-1:0]   note_number = '0;
  logic [VEL_W-1:0]    velocity    = '0;
  logic                out_valid;
  logic                out_stall   = 1'b0;
  logic [ACT_W-1:0]    action;
  logic [NOTE_W-1:0]   target_note;
  logic                accent_flag;
  logic [LEVEL_W-1:0]  accent_level;
  logic [VEL_W-1:0]    voice_velocity;
  logic [HELD_W-1:0]   notes_held;
  logic                cfg_valid   = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index   = '0;
  logic [CDATA_W-1:0]  cfg_data    = '0;

  int fail_count;
  int pending;
  int cycle_cnt   = 0;
  int stall_mode  = STALL_NONE;
  int mode_left   = 0;
  int run_left    = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  bit seq_now     = 1'b0;
  int thr_now     = 96;
  int voiced      = 0;

  mono_note_priority_stack dut (
    .clk, .rst, .in_valid, .in_stall, .req_type, .note_number, .velocity,
    .out_valid, .out_stall, .action, .target_note, .accent_flag, .accent_level,
    .voice_velocity, .notes_held, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  mnps_voice_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .req_type, .note_number, .velocity,
    .out_valid, .out_stall, .action, .target_note, .accent_flag, .accent_level,
    .voice_velocity, .notes_held, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall, switching to a randomly drawn pattern whenever the mode counter runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= !out_stall;
          run_left  <= $urandom_range(1, 25);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  // register write; valid stays high so back-to-back writes need no toggle
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, unused data bits randomized
  task automatic set_config(input logic seq, input logic [VEL_W-1:0] thr,
                            input logic [LEVEL_W-1:0] amt);
    write_reg(CFG_SEQ_RUNNING, {7'($urandom), seq});
    write_reg(CFG_ACC_THRESH, {1'($urandom), thr});
    write_reg(CFG_ACC_AMOUNT, amt);
    cfg_valid <= 1'b0;
    seq_now = seq;
    thr_now = thr;
  endtask

  // one item with burst and gap handling on the sender side
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [NOTE_W-1:0] note,
                           input logic [VEL_W-1:0] vel);
    int gap;
    in_valid    <= 1'b1;
    req_type    <= req;
    note_number <= note;
    velocity    <= vel;
    do @(posedge clk); while (in_stall);
    if (req != REQ_RSVD && (!seq_now || req == REQ_ALL_OFF)) voiced++;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // wait until every expected result has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // velocity, often right around the accent threshold
  function automatic logic [VEL_W-1:0] pick_vel();
    int v;
    if ($urandom_range(0, 3) == 0) begin
      v = thr_now + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 127) v = 127;
      return VEL_W'(v);
    end
    return VEL_W'($urandom);
  endfunction

  // presses and releases drawn from a narrow window of notes
  task automatic note_cluster();
    int base;
    int span;
    int len;
    int r;
    base = $urandom_range(0, 127);
    span = $urandom_range(2, 24);
    len  = $urandom_range(10, 60);
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        send_item(REQ_NOTE_ON, NOTE_W'(base + $urandom_range(0, span - 1)), pick_vel());
      else if (r < 93)
        send_item(REQ_NOTE_OFF, NOTE_W'(base + $urandom_range(0, span - 1)), VEL_W'($urandom));
      else if (r < 97)
        send_item(REQ_ALL_OFF, NOTE_W'($urandom), VEL_W'($urandom));
      else
        send_item(REQ_RSVD, NOTE_W'($urandom), VEL_W'($urandom));
    end
  endtask

  // fill the stack to near or past full, then release all at once, from the top down or at random
  task automatic fill_release();
    int first;
    int stride;
    int n;
    int i;
    first  = $urandom_range(0, 127);
    stride = $urandom_range(0, 63) * 2 + 1;
    n      = $urandom_range(15, 20);
    for (i = 0; i < n; i++) send_item(REQ_NOTE_ON, NOTE_W'(first + i * stride), pick_vel());
    case ($urandom_range(0, 3))
      0: send_item(REQ_ALL_OFF, NOTE_W'($urandom), VEL_W'($urandom));
      1: for (i = n - 1; i >= 0; i--)
           send_item(REQ_NOTE_OFF, NOTE_W'(first + i * stride), VEL_W'($urandom));
      default: for (i = 0; i < n + 2; i++)
        send_item(REQ_NOTE_OFF, NOTE_W'(first + $urandom_range(0, n - 1) * stride),
                  VEL_W'($urandom));
    endcase
  endtask

  // random mix of sequences until the phase has seen enough events
  task automatic run_phase(input int target);
    int start;
    int r;
    start = voiced;
    while (voiced - start < target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        note_cluster();
      end else if (r < 85) begin
        fill_release();
      end else begin
        repeat ($urandom_range(5, 15))
          send_item(REQ_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // opening settings, with a write to the unused index thrown in
    write_reg(CFG_UNUSED, CDATA_W'($urandom));
    set_config(1'b0, 7'd96, 8'd200);

    // directed events
    send_item(REQ_NOTE_OFF, 7'd60, 7'd0);     // release with nothing held
    send_item(REQ_ALL_OFF, 7'd0, 7'd0);       // all off on empty stack
    send_item(REQ_NOTE_ON, 7'd0, 7'd127);     // accented retrigger
    send_item(REQ_NOTE_ON, 7'd127, 7'd0);     // slide, accent depth kept
    send_item(REQ_NOTE_ON, 7'd64, 7'd96);     // slide, velocity at threshold
    send_item(REQ_NOTE_ON, 7'd65, 7'd95);     // slide, just under threshold
    send_item(REQ_NOTE_ON, 7'd0, 7'd50);      // held note pressed again moves to top
    send_item(REQ_NOTE_OFF, 7'd64, 7'd127);   // release below the top
    send_item(REQ_NOTE_OFF, 7'd0, 7'd0);      // release of top slides down
    send_item(REQ_NOTE_OFF, 7'd99, 7'd0);     // release of a note not held
    send_item(REQ_RSVD, 7'd85, 7'd42);        // reserved request
    send_item(REQ_RSVD, 7'd42, 7'd85);
    send_item(REQ_NOTE_OFF, 7'd65, 7'd0);
    send_item(REQ_NOTE_OFF, 7'd127, 7'd0);    // last note released, gate off
    send_item(REQ_NOTE_ON, 7'd10, 7'd127);
    send_item(REQ_ALL_OFF, 7'd10, 7'd127);    // all off with a note held
    send_item(REQ_NOTE_ON, 7'd10, 7'd10);     // unaccented retrigger clears depth
    send_item(REQ_NOTE_ON, 7'd20, 7'd100);
    send_item(REQ_NOTE_OFF, 7'd20, 7'd0);     // release of top slides back, gate stays open
    send_item(REQ_NOTE_ON, 7'd30, 7'd0);
    send_item(REQ_ALL_OFF, 7'd0, 7'd0);
    fill_release();                           // fill to near or past a full stack
    run_phase(200);

    // sequencer owns the voice: only all-off acts
    wait_idle();
    set_config(1'b1, 7'd0, 8'd0);
    send_item(REQ_NOTE_ON, 7'd40, 7'd127);
    send_item(REQ_NOTE_OFF, 7'd40, 7'd0);
    send_item(REQ_ALL_OFF, 7'd0, 7'd0);
    send_item(REQ_RSVD, 7'd0, 7'd0);
    repeat (40) send_item(REQ_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom));

    // every note accented, zero accent depth
    wait_idle();
    set_config(1'b0, 7'd0, 8'd0);
    run_phase(200);

    // highest threshold, full depth
    wait_idle();
    set_config(1'b0, 7'd127, 8'd255);
    run_phase(200);

    wait_idle();
    set_config(1'b0, 7'd1, 8'd128);
    run_phase(200);

    // sequencer again, held notes from before must survive
    wait_idle();
    set_config(1'b1, 7'd127, 8'd255);
    repeat (40) send_item(REQ_W'($urandom), NOTE_W'($urandom), VEL_W'($urandom));

    // random settings
    repeat (4) begin
      wait_idle();
      set_config(1'b0, VEL_W'($urandom), LEVEL_W'($urandom));
      run_phase(190);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
